@@ rtl/core/bdt_pkg.sv @@
// Shared types and constants of the button debounce, toggle and hold block.
`default_nettype none

package bdt_pkg;

    localparam int BTN_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 32;
    localparam int SECS_W     = 8;

    typedef enum logic [1:0] {
        MODE_IGNORE = 2'd0,
        MODE_DIRECT = 2'd1,
        MODE_TOGGLE = 2'd2,
        MODE_ANALOG = 2'd3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_USE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODES     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HORN      = 3'd4;

    localparam logic [15:0] RST_DEBOUNCE = 16'd50;
    localparam logic [15:0] RST_HOLD_THR = 16'd1000;
    localparam logic [3:0]  RST_IN_USE   = 4'd8;
    localparam logic [15:0] RST_MODES    = 16'h5555;
    localparam logic [3:0]  RST_HORN     = 4'd8;

    // Whole seconds from milliseconds: (ms >> 3) / 125 as a reciprocal multiply.
    localparam int          SEC_PRE   = 3;
    localparam int          SEC_SHIFT = 36;
    localparam logic [29:0] SEC_RECIP = 30'd549755814;

    typedef struct packed {
        logic              raw;
        logic [TIME_W-1:0] raw_time;
        logic              deb;
        logic              lvl;
        logic              hold;
        logic [TIME_W-1:0] held_ms;
        logic [TIME_W-1:0] press_time;
    } t_entry;

    typedef struct packed {
        logic [BTN_W-1:0]  which_button;
        logic              processed;
        logic              logical_pressed;
        logic              hold_active;
        logic [TIME_W-1:0] held_ms;
        logic              horn_update;
        logic              horn_pressed;
    } t_result;

    typedef struct packed {
        logic [BTN_W-1:0]  which_button;
        logic              processed;
        logic              logical_pressed;
        logic              hold_active;
        logic [SECS_W-1:0] hold_seconds;
        logic              horn_update;
        logic              horn_pressed;
    } t_report;

endpackage

`default_nettype wire

@@ rtl/core/bdt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bdt_update.sv @@
// Next-state logic for one button entry: debounce, direct level, toggle and hold.
`default_nettype none

module bdt_update (
    input  wire bdt_pkg::t_entry i_cur,
    input  wire logic            i_pressed,
    input  wire logic [31:0]     i_now,
    input  wire bdt_pkg::t_mode  i_mode,
    input  wire logic [15:0]     i_debounce_ms,
    input  wire logic [15:0]     i_hold_thr_ms,
    output bdt_pkg::t_entry      o_nxt
);
    import bdt_pkg::*;

    logic              raw_chg;
    logic [TIME_W-1:0] raw_age;
    logic              deb_take;
    logic              deb_new;
    logic              rose;
    logic              fell;
    logic [TIME_W-1:0] held;
    logic              held_over;

    assign raw_chg   = i_pressed != i_cur.raw;
    assign raw_age   = raw_chg ? '0 : (i_now - i_cur.raw_time);
    assign deb_take  = (i_pressed != i_cur.deb) && (raw_age >= {16'b0, i_debounce_ms});
    assign deb_new   = deb_take ? i_pressed : i_cur.deb;
    assign rose      = deb_new & ~i_cur.deb;
    assign fell      = ~deb_new & i_cur.deb;
    assign held      = rose ? '0 : (i_now - i_cur.press_time);
    assign held_over = held >= {16'b0, i_hold_thr_ms};

    always_comb begin
        o_nxt = i_cur;
        if (i_mode == MODE_DIRECT || i_mode == MODE_TOGGLE) begin
            o_nxt.raw = i_pressed;
            if (raw_chg) begin
                o_nxt.raw_time = i_now;
            end
            o_nxt.deb = deb_new;
            if (i_mode == MODE_DIRECT) begin
                o_nxt.lvl = deb_new;
            end else begin
                if (rose) begin
                    o_nxt.lvl        = ~i_cur.lvl;
                    o_nxt.press_time = i_now;
                    o_nxt.hold       = 1'b0;
                    o_nxt.held_ms    = '0;
                end
                if (deb_new) begin
                    if (held_over) begin
                        o_nxt.hold    = 1'b1;
                        o_nxt.held_ms = held;
                    end
                end else if (fell) begin
                    o_nxt.hold    = 1'b0;
                    o_nxt.held_ms = '0;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bdt_out.sv @@
// Result pipeline: hold-time register, seconds conversion and output register.
`default_nettype none

module bdt_out (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire bdt_pkg::t_result i_res,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output bdt_pkg::t_report      o_res
);
    import bdt_pkg::*;

    logic                     r_s2_vld;
    t_result                  r_s2;
    logic                     r_out_vld;
    t_report                  r_out;
    logic                     s2_go;
    logic [SEC_SHIFT+22:0]    prod;
    t_report                  n_out;

    assign s2_go   = !r_out_vld || i_ready;
    assign o_ready = !r_s2_vld || s2_go;
    assign prod    = r_s2.held_ms[TIME_W-1:SEC_PRE] * SEC_RECIP;

    always_comb begin
        n_out.which_button    = r_s2.which_button;
        n_out.processed       = r_s2.processed;
        n_out.logical_pressed = r_s2.logical_pressed;
        n_out.hold_active     = r_s2.hold_active;
        n_out.hold_seconds    = prod[SEC_SHIFT+SECS_W-1:SEC_SHIFT];
        n_out.horn_update     = r_s2.horn_update;
        n_out.horn_pressed    = r_s2.horn_pressed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s2_vld <= i_valid;
            end
            if (s2_go) begin
                r_out_vld <= r_s2_vld;
            end
        end
        if (o_ready && i_valid) begin
            r_s2 <= i_res;
        end
        if (s2_go && r_s2_vld) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;

    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld && !s2_go |=> r_s2_vld && $stable(r_s2))
        else $error("stalled hold-time stage lost its request");

    a_s2_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_s2_vld)
        else $error("accepted request did not reach the hold-time stage");

    a_unproc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.processed |->
        !r_out.horn_update && !r_out.logical_pressed && (r_out.hold_seconds == '0))
        else $error("skipped button reported nonzero state");

endmodule

`default_nettype wire

@@ rtl/core/button_debounce_toggle_hold.sv @@
// Top level of the button debounce, toggle and hold block.
// Takes one scan request per clock while the output is not stalled and returns one
// result per request, in order. The state RAM read is launched at the accepting edge.
// In the next cycle the read data is updated for debounce and toggle and written back
// as the update stage advances. The hold-time register then feeds the seconds multiply
// into the output register. Only a result waiting at the output stalls the input.
// Per-button state lives in a single RAM. The entry written in one cycle is forwarded
// to a read of the same button in the next. Per-entry valid bits make the state read
// as released at time zero after reset, so no clearing pass is needed.
`default_nettype none

module button_debounce_toggle_hold #(
    parameter int BUTTONS = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [bdt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [bdt_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [bdt_pkg::BTN_W-1:0]            i_button_index,
    input  wire logic                                 i_pin_level,
    input  wire logic [bdt_pkg::TIME_W-1:0]           i_now_ms,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [bdt_pkg::BTN_W-1:0]                 o_which_button,
    output logic                                      o_processed,
    output logic                                      o_logical_pressed,
    output logic                                      o_hold_active,
    output logic [bdt_pkg::SECS_W-1:0]                o_hold_seconds,
    output logic                                      o_horn_update,
    output logic                                      o_horn_pressed
);
    import bdt_pkg::*;

    localparam int          AW        = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam logic [5:0]  BTN_LIMIT = 6'(BUTTONS);

    logic [15:0]         r_debounce_ms;
    logic [15:0]         r_hold_thr_ms;
    logic [3:0]          r_in_use;
    logic [15:0]         r_modes;
    logic [3:0]          r_horn;

    logic [BUTTONS-1:0]  r_valid;
    logic                r_fwd_vld;
    logic [AW-1:0]       r_fwd_addr;
    t_entry              r_fwd_data;

    logic                r_s1_vld;
    logic [BTN_W-1:0]    r_s1_idx;
    logic                r_s1_pressed;
    logic [TIME_W-1:0]   r_s1_now;
    logic                r_s1_ent_vld;

    logic                in_acc;
    logic                s1_go;
    logic                out_ready;
    logic [AW+BTN_W-1:0] in_ext;
    logic [AW-1:0]       in_addr;
    logic                in_range;
    logic [AW+BTN_W-1:0] s1_ext;
    logic [AW-1:0]       s1_addr;
    logic                s1_in_range;
    t_mode               s1_mode;
    logic                s1_proc;
    logic                ram_we;
    logic [$bits(t_entry)-1:0] ram_rdata;
    t_entry              cur;
    t_entry              nxt;
    t_result             s1_res;
    t_report             rep;

    assign in_ext   = {{AW{1'b0}}, i_button_index};
    assign in_addr  = in_ext[AW-1:0];
    assign in_range = {3'b0, i_button_index} < BTN_LIMIT;
    assign s1_ext   = {{AW{1'b0}}, r_s1_idx};
    assign s1_addr  = s1_ext[AW-1:0];
    assign s1_in_range = {3'b0, r_s1_idx} < BTN_LIMIT;

    assign s1_go   = !r_s1_vld || out_ready;
    assign o_ready = s1_go;
    assign in_acc  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= RST_DEBOUNCE;
            r_hold_thr_ms <= RST_HOLD_THR;
            r_in_use      <= RST_IN_USE;
            r_modes       <= RST_MODES;
            r_horn        <= RST_HORN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE: r_debounce_ms <= i_cfg_data;
                REG_HOLD_THR: r_hold_thr_ms <= i_cfg_data;
                REG_IN_USE:   r_in_use      <= i_cfg_data[3:0];
                REG_MODES:    r_modes       <= i_cfg_data;
                REG_HORN:     r_horn        <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    bdt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (BUTTONS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (s1_addr),
        .i_wdata (nxt),
        .i_re    (in_acc),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == s1_addr)) begin
            cur = r_fwd_data;
        end else if (r_s1_ent_vld) begin
            cur = t_entry'(ram_rdata);
        end else begin
            cur = '0;
        end
    end

    assign s1_mode = t_mode'(r_modes[{r_s1_idx, 1'b0} +: 2]);
    assign s1_proc = s1_in_range && ({1'b0, r_s1_idx} < r_in_use) && (s1_mode != MODE_IGNORE);

    bdt_update u_update (
        .i_cur         (cur),
        .i_pressed     (~r_s1_pressed),
        .i_now         (r_s1_now),
        .i_mode        (s1_mode),
        .i_debounce_ms (r_debounce_ms),
        .i_hold_thr_ms (r_hold_thr_ms),
        .o_nxt         (nxt)
    );

    assign ram_we = r_s1_vld && s1_go && s1_proc;

    always_comb begin
        s1_res.which_button    = r_s1_idx;
        s1_res.processed       = s1_proc;
        s1_res.logical_pressed = s1_proc & nxt.lvl;
        s1_res.hold_active     = s1_proc & nxt.hold;
        s1_res.held_ms         = s1_proc ? nxt.held_ms : '0;
        s1_res.horn_update     = s1_proc && ({1'b0, r_s1_idx} == r_horn);
        s1_res.horn_pressed    = s1_proc && ({1'b0, r_s1_idx} == r_horn) && nxt.lvl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_valid   <= '0;
            r_fwd_vld <= 1'b0;
        end else begin
            if (s1_go) begin
                r_s1_vld <= i_valid;
            end
            if (ram_we) begin
                r_valid[s1_addr] <= 1'b1;
                r_fwd_vld        <= 1'b1;
            end
        end
        if (in_acc) begin
            r_s1_idx     <= i_button_index;
            r_s1_pressed <= i_pin_level;
            r_s1_now     <= i_now_ms;
            r_s1_ent_vld <= in_range && r_valid[in_addr];
        end
        if (ram_we) begin
            r_fwd_addr <= s1_addr;
            r_fwd_data <= nxt;
        end
    end

    bdt_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_vld),
        .o_ready (out_ready),
        .i_res   (s1_res),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (rep)
    );

    assign o_which_button    = rep.which_button;
    assign o_processed       = rep.processed;
    assign o_logical_pressed = rep.logical_pressed;
    assign o_hold_active     = rep.hold_active;
    assign o_hold_seconds    = rep.hold_seconds;
    assign o_horn_update     = rep.horn_update;
    assign o_horn_pressed    = rep.horn_pressed;

    a_fwd_tracks_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_fwd_vld && (r_fwd_addr == $past(s1_addr)))
        else $error("forwarding register missed a state write");

    a_s1_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_go |=> r_s1_vld && $stable(r_s1_idx) && $stable(r_s1_now))
        else $error("stalled update stage changed its request");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_vld)
        else $error("accepted request did not enter the update stage");

endmodule

`default_nettype wire

@@ bench/scan_result_checker.sv @@
// Checker for the button debounce block: predicts each scan result and compares it on arrival.
module scan_result_checker
    import bdt_pkg::*;
#(
    parameter int NUM_BUTTONS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_scan_valid,
    input  wire logic                  i_scan_ready,
    input  wire logic [BTN_W-1:0]      i_button_index,
    input  wire logic                  i_pin_level,
    input  wire logic [TIME_W-1:0]     i_now_ms,
    input  wire logic                  i_res_valid,
    input  wire logic                  i_res_ready,
    input  wire logic [BTN_W-1:0]      i_which_button,
    input  wire logic                  i_processed,
    input  wire logic                  i_logical_pressed,
    input  wire logic                  i_hold_active,
    input  wire logic [SECS_W-1:0]     i_hold_seconds,
    input  wire logic                  i_horn_update,
    input  wire logic                  i_horn_pressed,
    output int                         o_mismatches,
    output int                         o_outstanding,
    output int                         o_checked
);

    localparam logic [TIME_W-1:0] MS_PER_SECOND = 32'd1000;
    localparam int                MAX_PRINTED   = 100;

    logic              raw_lvl   [NUM_BUTTONS];
    logic [TIME_W-1:0] raw_since [NUM_BUTTONS];
    logic              deb_lvl   [NUM_BUTTONS];
    logic              out_lvl   [NUM_BUTTONS];
    logic              hold_on   [NUM_BUTTONS];
    logic [SECS_W-1:0] hold_secs [NUM_BUTTONS];
    logic [TIME_W-1:0] press_at  [NUM_BUTTONS];

    logic [15:0] debounce_ms;
    logic [15:0] hold_ms;
    logic [3:0]  in_use;
    logic [15:0] mode_word;
    logic [3:0]  horn_idx;

    t_report pending_reports[$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        o_checked     = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        o_mismatches++;
        if (o_mismatches <= MAX_PRINTED) begin
            $display("mismatch at %0t, result %0d: %s got %0d, expected %0d",
                     $time, o_checked, what, got, want);
        end
    endtask

    task automatic compare_field(input string what, input int got, input int want);
        if (got != want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Updates the state of one button for one scan sample and returns what it reports.
    function automatic t_report debounce_scan(logic [BTN_W-1:0] idx, logic pin,
                                              logic [TIME_W-1:0] now);
        t_mode             mode;
        t_report           rep;
        logic              prev;
        logic              rose;
        logic              fell;
        logic [TIME_W-1:0] held;
        mode = t_mode'(mode_word[2*idx +: 2]);
        rep = '0;
        rep.which_button = idx;
        if ({1'b0, idx} >= in_use || mode == MODE_IGNORE) begin
            return rep;
        end
        if (mode != MODE_ANALOG) begin
            prev = deb_lvl[idx];
            if (~pin != raw_lvl[idx]) begin
                raw_lvl[idx]   = ~pin;
                raw_since[idx] = now;
            end
            if (raw_lvl[idx] != deb_lvl[idx] && (now - raw_since[idx]) >= {16'd0, debounce_ms}) begin
                deb_lvl[idx] = raw_lvl[idx];
            end
            rose = deb_lvl[idx] & ~prev;
            fell = ~deb_lvl[idx] & prev;
            if (mode == MODE_DIRECT) begin
                out_lvl[idx] = deb_lvl[idx];
            end else begin
                if (rose) begin
                    out_lvl[idx]   = ~out_lvl[idx];
                    press_at[idx]  = now;
                    hold_on[idx]   = 1'b0;
                    hold_secs[idx] = '0;
                end
                if (deb_lvl[idx]) begin
                    held = now - press_at[idx];
                    if (held >= {16'd0, hold_ms}) begin
                        hold_on[idx]   = 1'b1;
                        hold_secs[idx] = SECS_W'(held / MS_PER_SECOND);
                    end
                end else if (fell) begin
                    hold_on[idx]   = 1'b0;
                    hold_secs[idx] = '0;
                end
            end
        end
        rep.processed       = 1'b1;
        rep.logical_pressed = out_lvl[idx];
        rep.hold_active     = hold_on[idx];
        rep.hold_seconds    = hold_secs[idx];
        if (horn_idx == {1'b0, idx}) begin
            rep.horn_update  = 1'b1;
            rep.horn_pressed = out_lvl[idx];
        end
        return rep;
    endfunction

    always @(posedge i_clk) begin : track
        t_report want;
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                raw_lvl[b]   = 1'b0;
                raw_since[b] = '0;
                deb_lvl[b]   = 1'b0;
                out_lvl[b]   = 1'b0;
                hold_on[b]   = 1'b0;
                hold_secs[b] = '0;
                press_at[b]  = '0;
            end
            debounce_ms = RST_DEBOUNCE;
            hold_ms     = RST_HOLD_THR;
            in_use      = RST_IN_USE;
            mode_word   = RST_MODES;
            horn_idx    = RST_HORN;
            pending_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DEBOUNCE: debounce_ms = i_cfg_data;
                    REG_HOLD_THR: hold_ms     = i_cfg_data;
                    REG_IN_USE:   in_use      = i_cfg_data[3:0];
                    REG_MODES:    mode_word   = i_cfg_data;
                    REG_HORN:     horn_idx    = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_scan_valid && i_scan_ready) begin
                pending_reports.push_back(debounce_scan(i_button_index, i_pin_level, i_now_ms));
            end
            if (i_res_valid && i_res_ready) begin
                if (pending_reports.size() == 0) begin
                    report_mismatch("result with no request waiting, button", i_which_button, 0);
                end else begin
                    want = pending_reports.pop_front();
                    compare_field("which_button", i_which_button, want.which_button);
                    compare_field("processed", i_processed, want.processed);
                    compare_field("logical_pressed", i_logical_pressed, want.logical_pressed);
                    compare_field("hold_active", i_hold_active, want.hold_active);
                    compare_field("hold_seconds", i_hold_seconds, want.hold_seconds);
                    compare_field("horn_update", i_horn_update, want.horn_update);
                    compare_field("horn_pressed", i_horn_pressed, want.horn_pressed);
                    o_checked++;
                end
            end
        end
        o_outstanding <= pending_reports.size();
    end

endmodule

@@ bench/tb_button_debounce_toggle_hold.sv @@
// Testbench top: drives scan requests and settings into the debounce block and gives the verdict.
module tb_button_debounce_toggle_hold;
    import bdt_pkg::*;

    localparam int     NUM_BUTTONS     = 8;
    localparam int     MAX_IDLE        = 17;
    localparam int     DRAIN_CYCLES    = 12;
    localparam int     PHASES          = 12;
    localparam int     ITEMS_PER_PHASE = 92;
    localparam longint RUN_LIMIT       = 64'd20_000_000;
    localparam logic   PIN_PRESSED     = 1'b0;
    localparam logic   PIN_RELEASED    = 1'b1;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = REG_DEBOUNCE;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_valid        = 1'b0;
    logic [BTN_W-1:0]      i_button_index = '0;
    logic                  i_pin_level    = PIN_RELEASED;
    logic [TIME_W-1:0]     i_now_ms       = '0;
    logic                  i_ready        = 1'b0;
    logic                  o_ready;
    logic                  o_valid;
    logic [BTN_W-1:0]      o_which_button;
    logic                  o_processed;
    logic                  o_logical_pressed;
    logic                  o_hold_active;
    logic [SECS_W-1:0]     o_hold_seconds;
    logic                  o_horn_update;
    logic                  o_horn_pressed;

    int mismatches;
    int outstanding;
    int results_checked;

    int                cur_debounce = RST_DEBOUNCE;
    int                cur_hold     = RST_HOLD_THR;
    logic [3:0]        cur_in_use   = RST_IN_USE;
    logic [15:0]       cur_modes    = RST_MODES;
    logic              send_calm    = 1'b0;
    logic              recv_calm    = 1'b0;
    logic [TIME_W-1:0] tick_ms      = '0;
    int                scans_sent   = 0;
    int                live_scans   = 0;

    always #10 i_clk = ~i_clk;

    button_debounce_toggle_hold #(
        .BUTTONS(NUM_BUTTONS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_button_index   (i_button_index),
        .i_pin_level      (i_pin_level),
        .i_now_ms         (i_now_ms),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_which_button   (o_which_button),
        .o_processed      (o_processed),
        .o_logical_pressed(o_logical_pressed),
        .o_hold_active    (o_hold_active),
        .o_hold_seconds   (o_hold_seconds),
        .o_horn_update    (o_horn_update),
        .o_horn_pressed   (o_horn_pressed)
    );

    scan_result_checker #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_scan_valid     (i_valid),
        .i_scan_ready     (o_ready),
        .i_button_index   (i_button_index),
        .i_pin_level      (i_pin_level),
        .i_now_ms         (i_now_ms),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_which_button   (o_which_button),
        .i_processed      (o_processed),
        .i_logical_pressed(o_logical_pressed),
        .i_hold_active    (o_hold_active),
        .i_hold_seconds   (o_hold_seconds),
        .i_horn_update    (o_horn_update),
        .i_horn_pressed   (o_horn_pressed),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding),
        .o_checked        (results_checked)
    );

    function automatic logic is_live(logic [BTN_W-1:0] idx);
        return ({1'b0, idx} < cur_in_use) && (cur_modes[2*idx +: 2] != MODE_IGNORE);
    endfunction

    function automatic logic [BTN_W-1:0] pick_button();
        logic [BTN_W-1:0] idx;
        idx = '0;
        for (int tries = 0; tries < 16; tries++) begin
            idx = BTN_W'($urandom_range(0, NUM_BUTTONS - 1));
            if (is_live(idx)) begin
                return idx;
            end
        end
        return idx;
    endfunction

    task automatic send_scan(input logic [BTN_W-1:0] idx, input logic pin,
                             input logic [TIME_W-1:0] now);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_button_index <= idx;
        i_pin_level    <= pin;
        i_now_ms       <= now;
        do @(posedge i_clk); while (!o_ready);
        scans_sent++;
        if (is_live(idx)) begin
            live_scans++;
        end
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic apply_settings(input logic [15:0] deb, input logic [15:0] hold,
                                  input logic [3:0] used, input logic [15:0] modes,
                                  input logic [3:0] horn);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_DEBOUNCE;
        i_cfg_data  <= deb;
        @(posedge i_clk);
        i_cfg_index <= REG_HOLD_THR;
        i_cfg_data  <= hold;
        @(posedge i_clk);
        i_cfg_index <= REG_IN_USE;
        i_cfg_data  <= {12'd0, used};
        @(posedge i_clk);
        i_cfg_index <= REG_MODES;
        i_cfg_data  <= modes;
        @(posedge i_clk);
        i_cfg_index <= REG_HORN;
        i_cfg_data  <= {12'd0, horn};
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        cur_debounce = deb;
        cur_hold     = hold;
        cur_in_use   = used;
        cur_modes    = modes;
    endtask

    task automatic advance_tick();
        case ($urandom_range(0, 19))
            0: tick_ms += $urandom_range(0, 400000);
            1: tick_ms += cur_debounce;
            2: tick_ms += cur_hold;
            3, 4, 5, 6, 7, 8, 9: tick_ms += $urandom_range(0, cur_debounce + 10);
            default: tick_ms += $urandom_range(0, cur_hold + 3000);
        endcase
    endtask

    // Contact chatter around the new level, then the level held for a while.
    task automatic settle(input logic [BTN_W-1:0] idx, input logic level);
        int chatter;
        int steady;
        chatter = $urandom_range(0, 3);
        steady  = $urandom_range(1, 6);
        for (int k = 0; k < chatter; k++) begin
            tick_ms += $urandom_range(0, cur_debounce / 2 + 1);
            send_scan(idx, level ^ k[0], tick_ms);
        end
        for (int k = 0; k < steady; k++) begin
            advance_tick();
            send_scan(idx, level, tick_ms);
        end
    endtask

    initial begin : result_sink
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = recv_calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : stimulus
        logic [15:0]      deb;
        logic [15:0]      hold;
        logic [3:0]       used;
        logic [15:0]      modes;
        logic [3:0]       horn;
        logic [BTN_W-1:0] idx;
        int               start_sent;
        int               start_live;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Direct buttons under the reset settings, including a debounce across the tick wrap.
        send_scan(3'd0, PIN_RELEASED, 32'd0);
        send_scan(3'd0, PIN_PRESSED, 32'd0);
        send_scan(3'd0, PIN_PRESSED, 32'd49);
        send_scan(3'd0, PIN_PRESSED, 32'd50);
        send_scan(3'd7, PIN_PRESSED, 32'hFFFF_FFFF);
        send_scan(3'd7, PIN_PRESSED, 32'd48);
        send_scan(3'd7, PIN_PRESSED, 32'd49);
        send_scan(3'd0, PIN_RELEASED, 32'd100);
        send_scan(3'd0, PIN_PRESSED, 32'd120);
        send_scan(3'd0, PIN_RELEASED, 32'd200);
        send_scan(3'd0, PIN_RELEASED, 32'd250);

        // Toggle buttons with hold reporting, including the seconds count wrapping past 255.
        apply_settings(16'd0, 16'd1000, 4'd8, {8{MODE_TOGGLE}}, 4'd2);
        send_scan(3'd2, PIN_PRESSED, 32'd1000);
        send_scan(3'd2, PIN_PRESSED, 32'd1999);
        send_scan(3'd2, PIN_PRESSED, 32'd2000);
        send_scan(3'd2, PIN_PRESSED, 32'd257999);
        send_scan(3'd2, PIN_RELEASED, 32'd258000);
        send_scan(3'd2, PIN_PRESSED, 32'd258001);
        send_scan(3'd2, PIN_PRESSED, 32'd261500);

        // Stale hold on a button switched to direct, analog horn, ignored and unused buttons.
        modes = {8{MODE_TOGGLE}};
        modes[5:4] = MODE_DIRECT;
        modes[7:6] = MODE_ANALOG;
        modes[9:8] = MODE_IGNORE;
        apply_settings(16'd0, 16'd1000, 4'd6, modes, 4'd3);
        send_scan(3'd2, PIN_PRESSED, 32'd262000);
        send_scan(3'd3, PIN_PRESSED, 32'd262000);
        send_scan(3'd4, PIN_PRESSED, 32'd262000);
        send_scan(3'd6, PIN_PRESSED, 32'd262000);
        send_scan(3'd5, PIN_PRESSED, 32'd0);

        apply_settings(16'd0, 16'd1000, 4'd0, modes, 4'd8);
        send_scan(3'd0, PIN_PRESSED, 32'd5);

        for (int phase = 0; phase < PHASES; phase++) begin
            deb  = (phase % 4 == 0) ? 16'd0 :
                   (phase % 4 == 1) ? 16'hFFFF : 16'($urandom_range(0, 200));
            hold = (phase % 3 == 0) ? 16'd0 :
                   (phase == 4 || phase == 10) ? 16'hFFFF : 16'($urandom_range(0, 3000));
            used = (phase == 2) ? 4'd0 :
                   (phase % 3 == 1) ? 4'd8 : 4'($urandom_range(1, 8));
            modes = (phase % 3 == 0) ? {8{MODE_TOGGLE}} : 16'($urandom());
            horn = (phase % 4 == 0) ? 4'd8 : 4'($urandom_range(0, 7));
            apply_settings(deb, hold, used, modes, horn);
            send_calm = (phase % 4 == 1) || (phase % 4 == 3);
            recv_calm = (phase % 4 == 2) || (phase % 4 == 3);
            tick_ms = $urandom();
            start_sent = scans_sent;
            start_live = live_scans;
            while (live_scans - start_live < ITEMS_PER_PHASE &&
                   scans_sent - start_sent < 2 * ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_scan(BTN_W'($urandom_range(0, NUM_BUTTONS - 1)),
                              1'($urandom_range(0, 1)),
                              $urandom_range(0, 1) ? $urandom() : tick_ms + $urandom_range(0, 30));
                end else begin
                    idx = pick_button();
                    settle(idx, PIN_PRESSED);
                    if ($urandom_range(0, 4) != 0) begin
                        settle(idx, PIN_RELEASED);
                    end
                end
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d scan requests (%0d on processed buttons) over %0d setting phases.",
                 scans_sent, live_scans, PHASES + 4);
        $display("Compared %0d results field by field, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("Run limit reached with %0d results outstanding.", outstanding);
        $display("== FAIL ==");
        $finish;
    end

endmodule
